### rtl/core/rgvg_pkg.sv
// ============================================================================
// rgvg_pkg
// Shared types, constants and helper functions for the radial gauge vertex
// generator: payload structs, edge codes, angle and edge arithmetic, and the
// reciprocal table used by the tangent polynomial.
// ============================================================================
package rgvg_pkg;

   // Queue depth between the tangent unit and the vertex emitter
   localparam int unsigned QUEUE_DEPTH = 2;

   // Fixed-point constants
   localparam logic [16:0] TURN_ONE     = 17'd65536;
   localparam logic [15:0] HALF_Q16     = 16'd32768;
   localparam logic [13:0] EIGHTH_TURN  = 14'd8192;
   localparam logic [16:0] ANGLE_TO_Q30 = 17'd102944;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [3:0]  LAST_VERTEX  = 4'd9;

   // Edge codes
   localparam logic [1:0] EDGE_RIGHT  = 2'd0;
   localparam logic [1:0] EDGE_TOP    = 2'd1;
   localparam logic [1:0] EDGE_LEFT   = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   // Polynomial chains
   localparam logic CHAIN_SIN = 1'b0;
   localparam logic CHAIN_COS = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_QUARTER = 2'd0;
   localparam logic [1:0] CSR_REVERSE       = 2'd1;
   localparam logic [1:0] CSR_GAUGE_SIZE    = 2'd2;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        level;
      logic [15:0]        level_max;
      logic [15:0]        scale_ratio;
   } req_type;

   typedef struct packed {
      logic [3:0]         vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic               last;
   } rsp_type;

   // Front output: fill fraction and scale product
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [16:0]        frac;
      logic [31:0]        mul;
   } frac_type;

   // Tangent unit output: adds the half-tangent magnitude
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [16:0]        frac;
      logic [31:0]        mul;
      logic [15:0]        hmag;
   } gauge_type;

   typedef struct packed {
      logic [1:0]         side;
      logic signed [15:0] delta;
   } edge_pos_type;

   // Angle in Q0.16 turns from start quarter, direction and turn amount
   function automatic logic [15:0] angle_of(input logic [16:0] t, input logic [1:0] sq,
                                            input logic rev);
      logic [15:0] base;
      begin
         base = {sq, 14'd0};
         angle_of = rev ? (base - t[15:0]) : (base + t[15:0]);
      end
   endfunction

   // Edge of the unit square and signed distance from its centre angle
   function automatic edge_pos_type edge_of(input logic [15:0] a);
      edge_pos_type e;
      logic [15:0]  ctr;
      begin
         if (a >= 16'd8192 && a <= 16'd24576) begin
            e.side = EDGE_TOP;
            ctr    = 16'd16384;
         end else if (a >= 16'd8192 && a <= 16'd40960) begin
            e.side = EDGE_LEFT;
            ctr    = 16'd32768;
         end else if (a >= 16'd8192 && a <= 16'd57344) begin
            e.side = EDGE_BOTTOM;
            ctr    = 16'd49152;
         end else begin
            e.side = EDGE_RIGHT;
            ctr    = 16'd0;
         end
         e.delta = $signed(a - ctr);
         edge_of = e;
      end
   endfunction

   // Horner divisors of the sine and cosine chains
   function automatic logic [6:0] divisor_of(input logic chain, input logic [2:0] lvl);
      begin
         case ({chain, lvl})
            {CHAIN_SIN, 3'd0}: divisor_of = 7'd72;
            {CHAIN_SIN, 3'd1}: divisor_of = 7'd42;
            {CHAIN_SIN, 3'd2}: divisor_of = 7'd20;
            {CHAIN_SIN, 3'd3}: divisor_of = 7'd6;
            {CHAIN_COS, 3'd0}: divisor_of = 7'd90;
            {CHAIN_COS, 3'd1}: divisor_of = 7'd56;
            {CHAIN_COS, 3'd2}: divisor_of = 7'd30;
            {CHAIN_COS, 3'd3}: divisor_of = 7'd12;
            {CHAIN_COS, 3'd4}: divisor_of = 7'd2;
            default:           divisor_of = 7'd1;
         endcase
      end
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [31:0] recip_of(input logic chain, input logic [2:0] lvl);
      begin
         case ({chain, lvl})
            {CHAIN_SIN, 3'd0}: recip_of = 32'd59652323;
            {CHAIN_SIN, 3'd1}: recip_of = 32'd102261126;
            {CHAIN_SIN, 3'd2}: recip_of = 32'd214748364;
            {CHAIN_SIN, 3'd3}: recip_of = 32'd715827882;
            {CHAIN_COS, 3'd0}: recip_of = 32'd47721858;
            {CHAIN_COS, 3'd1}: recip_of = 32'd76695844;
            {CHAIN_COS, 3'd2}: recip_of = 32'd143165576;
            {CHAIN_COS, 3'd3}: recip_of = 32'd357913941;
            {CHAIN_COS, 3'd4}: recip_of = 32'd2147483648;
            default:           recip_of = 32'd0;
         endcase
      end
   endfunction

endpackage

### rtl/core/rgvg_front.sv
// ============================================================================
// rgvg_front
// Accepts gauge requests, forms the size product and works out the fill
// fraction level/level_max in Q0.16 with a two-bit-per-cycle divider.
// ============================================================================
module rgvg_front import rgvg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] gauge_size,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output frac_type    out_data
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] lmax_ff, lmax_in;
   frac_type    item_ff, item_in;
   logic        accept;
   logic [16:0] r;
   logic [15:0] q;

   assign in_ready  = !busy_ff && (!done_ff || out_ready);
   assign accept    = in_valid && in_ready;
   assign out_valid = done_ff;
   assign out_data  = item_ff;

   // Two restoring steps per cycle
   always_comb begin
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < 2; i++) begin
         r = {r[15:0], 1'b0};
         if (r >= {1'b0, lmax_ff}) begin
            r = r - {1'b0, lmax_ff};
            q = {q[14:0], 1'b1};
         end else begin
            q = {q[14:0], 1'b0};
         end
      end
   end

   // Request intake and divider sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      lmax_in = lmax_ff;
      item_in = item_ff;
      if (done_ff && out_ready) begin
         done_in = 1'b0;
      end
      if (accept) begin
         item_in.cx  = in_data.center_x;
         item_in.cy  = in_data.center_y;
         item_in.mul = 32'(in_data.scale_ratio) * 32'(gauge_size);
         lmax_in     = in_data.level_max;
         rem_in      = {1'b0, in_data.level};
         quo_in      = 16'd0;
         cnt_in      = 3'd0;
         if (in_data.level_max == 16'd0) begin
            item_in.frac = 17'd0;
            done_in      = 1'b1;
         end else if (in_data.level >= in_data.level_max) begin
            item_in.frac = TURN_ONE;
            done_in      = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in      = 1'b0;
            done_in      = 1'b1;
            item_in.frac = {1'b0, q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      lmax_ff <= lmax_in;
      item_ff <= item_in;
   end

endmodule

### rtl/core/rgvg_tan.sv
// ============================================================================
// rgvg_tan
// Half-tangent unit: 0.5*tan of the fill angle's offset from its edge centre.
// Sine and cosine Horner chains share one three-stage multiply loop, then a
// two-bit-per-cycle divider forms s/c.
// ============================================================================
module rgvg_tan import rgvg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  start_quarter,
   input  logic        reverse_direction,
   input  logic        in_valid,
   output logic        in_ready,
   input  frac_type    in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output gauge_type   out_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_XMUL  = 3'd1;
   localparam logic [2:0] ST_X2MUL = 3'd2;
   localparam logic [2:0] ST_POLY  = 3'd3;
   localparam logic [2:0] ST_DINIT = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]   state_ff, state_in;
   frac_type     item_ff, item_in;
   logic [12:0]  m_ff, m_in;
   logic [29:0]  x_ff, x_in;
   logic [29:0]  x2_ff, x2_in;
   logic [30:0]  ts_ff, ts_in;
   logic [30:0]  tc_ff, tc_in;
   logic [1:0]   slot_ff, slot_in;
   logic [2:0]   lvl_ff, lvl_in;
   logic         mv_ff, mv_in;
   logic         mch_ff;
   logic [2:0]   mlvl_ff;
   logic [30:0]  p_ff;
   logic         rv_ff, rv_in;
   logic         rch_ff;
   logic [2:0]   rlvl_ff;
   logic [30:0]  rp_ff;
   logic [30:0]  q0_ff;
   logic [31:0]  rem_ff, rem_in;
   logic [17:0]  nlow_ff, nlow_in;
   logic [17:0]  quo_ff, quo_in;
   logic [3:0]   dcnt_ff, dcnt_in;
   logic [15:0]  hmag_ff, hmag_in;

   logic         accept;
   edge_pos_type ep;
   logic [15:0]  dabs;
   logic         issue;
   logic         chain;
   logic [29:0]  mul_a;
   logic [30:0]  mul_b;
   logic [60:0]  prod;
   logic [62:0]  rprod;
   logic [6:0]   dvs;
   logic [37:0]  qn;
   logic [30:0]  rmd;
   logic [30:0]  q;
   logic [45:0]  num;
   logic [29:0]  xprod;
   logic [59:0]  x2prod;
   logic [31:0]  r;
   logic [17:0]  nl;
   logic [17:0]  dq;

   assign in_ready  = (state_ff == ST_IDLE) || (state_ff == ST_DONE && out_ready);
   assign accept    = in_valid && in_ready;
   assign out_valid = (state_ff == ST_DONE);
   assign out_data  = '{cx: item_ff.cx, cy: item_ff.cy, frac: item_ff.frac,
                        mul: item_ff.mul, hmag: hmag_ff};

   // Angle offset of the incoming fill fraction
   always_comb begin
      ep   = edge_of(angle_of(in_data.frac, start_quarter, reverse_direction));
      dabs = ep.delta[15] ? 16'(-ep.delta) : 16'(ep.delta);
   end

   // Multiply loop: M stage
   assign issue  = (state_ff == ST_POLY) && (slot_ff != 2'd2) && (lvl_ff <= 3'd4);
   assign chain  = slot_ff[0];
   assign mul_a  = (chain == CHAIN_SIN && lvl_ff == 3'd4) ? x_ff : x2_ff;
   assign mul_b  = (chain == CHAIN_COS) ? tc_ff : ts_ff;
   assign prod   = 61'(mul_a) * 61'(mul_b);

   // R stage: reciprocal multiply
   assign rprod  = 63'(p_ff) * 63'(recip_of(mch_ff, mlvl_ff));

   // C stage: one correction step
   assign dvs = divisor_of(rch_ff, rlvl_ff);
   assign qn  = 38'(q0_ff) * 38'(dvs);
   assign rmd = rp_ff - qn[30:0];
   assign q   = (rmd >= 31'(dvs)) ? q0_ff + 31'd1 : q0_ff;

   assign xprod  = 30'(m_ff) * 30'(ANGLE_TO_Q30);
   assign x2prod = 60'(x_ff) * 60'(x_ff);
   assign num    = 46'({ts_ff, 15'd0}) + 46'(tc_ff[30:1]);

   // Two restoring steps per cycle for s/c
   always_comb begin
      r  = rem_ff;
      nl = nlow_ff;
      dq = quo_ff;
      for (int i = 0; i < 2; i++) begin
         r  = {r[30:0], nl[17]};
         nl = {nl[16:0], 1'b0};
         if (r >= {1'b0, tc_ff}) begin
            r  = r - {1'b0, tc_ff};
            dq = {dq[16:0], 1'b1};
         end else begin
            dq = {dq[16:0], 1'b0};
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      m_in     = m_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      ts_in    = ts_ff;
      tc_in    = tc_ff;
      slot_in  = slot_ff;
      lvl_in   = lvl_ff;
      mv_in    = issue;
      rv_in    = mv_ff;
      rem_in   = rem_ff;
      nlow_in  = nlow_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      hmag_in  = hmag_ff;

      // Chain write-back
      if (rv_ff) begin
         if (rch_ff == CHAIN_SIN && rlvl_ff == 3'd4) begin
            ts_in = rp_ff;
         end else if (rch_ff == CHAIN_SIN) begin
            ts_in = ONE_Q30 - q;
         end else begin
            tc_in = ONE_Q30 - q;
         end
      end

      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE && out_ready) begin
               state_in = ST_IDLE;
            end
            if (accept) begin
               item_in = in_data;
               m_in    = dabs[12:0];
               if (dabs == 16'd0) begin
                  hmag_in  = 16'd0;
                  state_in = ST_DONE;
               end else if (dabs >= 16'(EIGHTH_TURN)) begin
                  hmag_in  = HALF_Q16;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_XMUL;
               end
            end
         end
         ST_XMUL: begin
            x_in     = xprod;
            state_in = ST_X2MUL;
         end
         ST_X2MUL: begin
            x2_in    = x2prod[59:30];
            ts_in    = ONE_Q30;
            tc_in    = ONE_Q30;
            slot_in  = 2'd0;
            lvl_in   = 3'd0;
            state_in = ST_POLY;
         end
         ST_POLY: begin
            if (slot_ff == 2'd2) begin
               slot_in = 2'd0;
               lvl_in  = lvl_ff + 3'd1;
            end else begin
               slot_in = slot_ff + 2'd1;
            end
            if (rv_ff && rch_ff == CHAIN_COS && rlvl_ff == 3'd4) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            rem_in   = 32'(num[45:18]);
            nlow_in  = num[17:0];
            quo_in   = 18'd0;
            dcnt_in  = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = r;
            nlow_in = nl;
            quo_in  = dq;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'd8) begin
               hmag_in  = (dq > 18'(HALF_Q16)) ? HALF_Q16 : dq[15:0];
               state_in = ST_DONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         slot_ff  <= 2'd0;
         lvl_ff   <= 3'd0;
         dcnt_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         mv_ff    <= mv_in;
         rv_ff    <= rv_in;
         slot_ff  <= slot_in;
         lvl_ff   <= lvl_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      m_ff    <= m_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      ts_ff   <= ts_in;
      tc_ff   <= tc_in;
      mch_ff  <= chain;
      mlvl_ff <= lvl_ff;
      p_ff    <= prod[60:30];
      rch_ff  <= mch_ff;
      rlvl_ff <= mlvl_ff;
      rp_ff   <= p_ff;
      q0_ff   <= rprod[62:32];
      rem_ff  <= rem_in;
      nlow_ff <= nlow_in;
      quo_ff  <= quo_in;
      hmag_ff <= hmag_in;
   end

endmodule

### rtl/core/rgvg_fifo.sv
// ============================================================================
// rgvg_fifo
// Short register queue between the tangent unit and the vertex emitter.
// ============================================================================
module rgvg_fifo import rgvg_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  gauge_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output gauge_type pop_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   gauge_type       mem_ff [DEPTH];
   logic [PW-1:0]   wp_ff, wp_in;
   logic [PW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

### rtl/core/rgvg_back.sv
// ============================================================================
// rgvg_back
// Vertex emitter: walks vertices 0..9 of the queued gauge, picks each edge
// offset, scales it to screen units and drives the response register.
// ============================================================================
module rgvg_back import rgvg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] start_quarter,
   input  logic       reverse_direction,
   input  logic       in_valid,
   output logic       in_ready,
   input  gauge_type  in_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic               adv;
   logic [3:0]         k_ff, k_in;
   logic [3:0]         km1;
   logic [16:0]        cap;
   logic [16:0]        t;
   edge_pos_type       ep;
   logic [15:0]        dabs;
   logic [16:0]        mag;
   logic signed [16:0] h;
   logic signed [16:0] ox, oy;

   logic               s1_vld_ff;
   logic [3:0]         s1_k_ff;
   logic signed [16:0] s1_ox_ff, s1_oy_ff;
   logic signed [15:0] s1_cx_ff, s1_cy_ff;
   logic [31:0]        s1_mul_ff;

   logic               s2_vld_ff;
   logic [3:0]         s2_k_ff;
   logic signed [16:0] s2_ox_ff, s2_oy_ff;
   logic signed [15:0] s2_cx_ff, s2_cy_ff;
   logic [48:0]        s2_px_ff, s2_py_ff;

   logic               out_vld_ff;
   rsp_type            out_ff, out_in;

   logic [16:0]        ax, ay;
   logic [48:0]        rx_sum, ry_sum;
   logic [31:0]        rx, ry;
   logic [17:0]        tu, tv;

   // Whole pipeline moves when the response register is free
   assign adv       = !out_vld_ff || !rsp_stall;
   assign in_ready  = adv && (k_ff == LAST_VERTEX);
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Vertex counter
   always_comb begin
      k_in = k_ff;
      if (in_valid && adv) begin
         k_in = (k_ff == LAST_VERTEX) ? 4'd0 : k_ff + 4'd1;
      end
   end

   // Edge offsets of vertex k
   always_comb begin
      km1  = k_ff - 4'd1;
      cap  = {km1, 13'd0};
      t    = (in_data.frac < cap) ? in_data.frac : cap;
      ep   = edge_of(angle_of(t, start_quarter, reverse_direction));
      dabs = ep.delta[15] ? 16'(-ep.delta) : 16'(ep.delta);
      if (dabs == 16'(EIGHTH_TURN)) begin
         mag = 17'(HALF_Q16);
      end else if (dabs == 16'd0) begin
         mag = 17'd0;
      end else begin
         mag = {1'b0, in_data.hmag};
      end
      h = ep.delta[15] ? -$signed(mag) : $signed(mag);
      case (ep.side)
         EDGE_RIGHT: begin
            ox = 17'sd32768;
            oy = h;
         end
         EDGE_TOP: begin
            ox = -h;
            oy = 17'sd32768;
         end
         EDGE_LEFT: begin
            ox = -17'sd32768;
            oy = -h;
         end
         default: begin
            ox = h;
            oy = -17'sd32768;
         end
      endcase
      if (k_ff == 4'd0) begin
         ox = 17'sd0;
         oy = 17'sd0;
      end
   end

   // Magnitudes for scaling
   assign ax = s1_ox_ff[16] ? 17'(-s1_ox_ff) : 17'(s1_ox_ff);
   assign ay = s1_oy_ff[16] ? 17'(-s1_oy_ff) : 17'(s1_oy_ff);

   // Rounding, sign and final position
   always_comb begin
      rx_sum = s2_px_ff + 49'(1 << 27);
      ry_sum = s2_py_ff + 49'(1 << 27);
      rx     = 32'(rx_sum[48:28]);
      ry     = 32'(ry_sum[48:28]);
      tu     = 18'({s2_ox_ff[16], s2_ox_ff}) + 18'(HALF_Q16);
      tv     = 18'({s2_oy_ff[16], s2_oy_ff}) + 18'(HALF_Q16);
      out_in.vertex_index = s2_k_ff;
      out_in.pos_x = 32'(s2_cx_ff) + (s2_ox_ff[16] ? -rx : rx);
      out_in.pos_y = 32'(s2_cy_ff) + (s2_oy_ff[16] ? -ry : ry);
      out_in.tex_u = tu[16:0];
      out_in.tex_v = tv[16:0];
      out_in.last  = (s2_k_ff == LAST_VERTEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= 4'd0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (adv) begin
            s1_vld_ff  <= in_valid;
            s2_vld_ff  <= s1_vld_ff;
            out_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_k_ff   <= k_ff;
         s1_ox_ff  <= ox;
         s1_oy_ff  <= oy;
         s1_cx_ff  <= in_data.cx;
         s1_cy_ff  <= in_data.cy;
         s1_mul_ff <= in_data.mul;
         s2_k_ff   <= s1_k_ff;
         s2_ox_ff  <= s1_ox_ff;
         s2_oy_ff  <= s1_oy_ff;
         s2_cx_ff  <= s1_cx_ff;
         s2_cy_ff  <= s1_cy_ff;
         s2_px_ff  <= 49'(ax) * 49'(s1_mul_ff);
         s2_py_ff  <= 49'(ay) * 49'(s1_mul_ff);
         out_ff    <= out_in;
      end
   end

endmodule

### rtl/core/radial_gauge_vertex_generator_core.sv
// ============================================================================
// radial_gauge_vertex_generator_core
// Radial clock-wipe gauge vertex generator: one request in, ten vertices out.
// ============================================================================
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_type  (centre, level, max, ratio)
//   rsp      out        rsp_valid/stall    rsp_type  (index, position, tex, last)
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// Each request yields ten responses, one per cycle when rsp is not stalled.
// In the half-tangent unit a request passes two setup multiplies, the Horner
// rounds, a divider set-up state, the divider steps and a hand-off state, and
// the unit takes no new request until its result is handed off; requests
// whose fill lands on a corner or an edge centre go straight to the hand-off.
// The fraction divider, tangent unit and emitter overlap across requests,
// with a short queue before the emitter.
// Reset is synchronous; it clears control state and restores the registers.
// ============================================================================
module radial_gauge_vertex_generator_core import rgvg_pkg::*; #(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [1:0]  start_quarter_ff, start_quarter_in;
   logic        reverse_ff, reverse_in;
   logic [15:0] gauge_size_ff, gauge_size_in;

   logic        fr_ready;
   logic        fr_valid;
   frac_type    fr_data;
   logic        tn_ready;
   logic        tn_valid;
   gauge_type   tn_data;
   logic        q_ready;
   logic        q_valid;
   gauge_type   q_data;
   logic        bk_ready;

   assign csr_ready = 1'b1;
   assign req_stall = !fr_ready;

   // Register writes
   always_comb begin
      start_quarter_in = start_quarter_ff;
      reverse_in       = reverse_ff;
      gauge_size_in    = gauge_size_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_QUARTER: start_quarter_in = csr_wdata[1:0];
            CSR_REVERSE:       reverse_in       = csr_wdata[0];
            CSR_GAUGE_SIZE:    gauge_size_in    = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_quarter_ff <= 2'd0;
         reverse_ff       <= 1'b0;
         gauge_size_ff    <= 16'd12800;
      end else begin
         start_quarter_ff <= start_quarter_in;
         reverse_ff       <= reverse_in;
         gauge_size_ff    <= gauge_size_in;
      end
   end

   rgvg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .gauge_size (gauge_size_ff),
      .in_valid   (req_valid),
      .in_ready   (fr_ready),
      .in_data    (req_data),
      .out_valid  (fr_valid),
      .out_ready  (tn_ready),
      .out_data   (fr_data)
   );

   rgvg_tan u_tan (
      .clock             (clock),
      .reset             (reset),
      .start_quarter     (start_quarter_ff),
      .reverse_direction (reverse_ff),
      .in_valid          (fr_valid),
      .in_ready          (tn_ready),
      .in_data           (fr_data),
      .out_valid         (tn_valid),
      .out_ready         (q_ready),
      .out_data          (tn_data)
   );

   rgvg_fifo #(
      .DEPTH (QDEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (tn_valid),
      .push_ready (q_ready),
      .push_data  (tn_data),
      .pop_valid  (q_valid),
      .pop_ready  (bk_ready),
      .pop_data   (q_data)
   );

   rgvg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .start_quarter     (start_quarter_ff),
      .reverse_direction (reverse_ff),
      .in_valid          (q_valid),
      .in_ready          (bk_ready),
      .in_data           (q_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data)
   );

endmodule

### tb/tb_radial_gauge_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// Testbench for radial_gauge_vertex_generator_core
// Drives gauge requests through the req channel under several register
// settings. A local predictor works out the ten vertices of each accepted
// request, and each response is compared as a whole against the oldest
// of them. Both sides idle in random bursts, and the response side also
// holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_radial_gauge_vertex_generator_core import rgvg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT  = 400000;
   localparam int DRAIN_WAIT = 100;
   localparam int LONG_HOLD  = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // register copies used for prediction
   logic [1:0]  cfg_quarter = 2'd0;
   logic        cfg_reverse = 1'b0;
   logic [15:0] cfg_size    = 16'd12800;

   req_type pending_requests[$];
   rsp_type vertices_due[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   int      hold_left = 0;
   bit      hold_pending = 1'b0;
   bit      quiet = 1'b0;

   radial_gauge_vertex_generator_core uut (.*);

   always #1 clock = ~clock;

   // 0.5 * tan of m/65536 turn, Q0.16
   function automatic longint unsigned half_tan_q16(input longint unsigned m);
      longint unsigned x, x2, t, s, c, h;
      if (m >= 8192) return 64'd32768;
      x  = m * 64'd102944;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      t  = (64'd1 << 30) - x2 / 90;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 56;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      c  = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
      h  = (s * 32768 + c / 2) / c;
      return (h > 32768) ? 64'd32768 : h;
   endfunction

   // screen offset, magnitude rounded half away from zero
   function automatic longint scaled_offset(input longint off, input longint unsigned mul);
      longint unsigned mag;
      mag = (((off < 0) ? -off : off) * mul + (64'd1 << 27)) >> 28;
      return (off < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   // push the ten vertices a request should produce
   function automatic void predict_gauge_vertices(input req_type r);
      longint unsigned frac, mul, q, cap, t;
      longint          cx, cy, d, h, ox, oy;
      logic [15:0]     a, ctr;
      logic [1:0]      side;
      rsp_type         v;
      cx   = r.center_x;
      cy   = r.center_y;
      mul  = longint'(cfg_size) * r.scale_ratio;
      frac = 0;
      if (r.level_max != 0) begin
         q    = (longint'(r.level) << 16) / r.level_max;
         frac = (q > 65536) ? 64'd65536 : q;
      end
      v = '{vertex_index: 4'd0, pos_x: 32'(cx), pos_y: 32'(cy),
            tex_u: 17'd32768, tex_v: 17'd32768, last: 1'b0};
      vertices_due.push_back(v);
      for (int k = 1; k <= 9; k++) begin
         cap = (k - 1) * 8192;
         t   = (frac < cap) ? frac : cap;
         a   = cfg_reverse ? 16'({cfg_quarter, 14'd0} - t) : 16'({cfg_quarter, 14'd0} + t);
         if (a >= 16'd8192 && a <= 16'd24576) begin
            side = EDGE_TOP;    ctr = 16'd16384;
         end else if (a >= 16'd8192 && a <= 16'd40960) begin
            side = EDGE_LEFT;   ctr = 16'd32768;
         end else if (a >= 16'd8192 && a <= 16'd57344) begin
            side = EDGE_BOTTOM; ctr = 16'd49152;
         end else begin
            side = EDGE_RIGHT;  ctr = 16'd0;
         end
         d = longint'($signed(16'(a - ctr)));
         h = (d < 0) ? -longint'(half_tan_q16(-d)) : longint'(half_tan_q16(d));
         case (side)
            EDGE_RIGHT: begin ox = 32768;  oy = h;      end
            EDGE_TOP:   begin ox = -h;     oy = 32768;  end
            EDGE_LEFT:  begin ox = -32768; oy = -h;     end
            default:    begin ox = h;      oy = -32768; end
         endcase
         v.vertex_index = 4'(k);
         v.pos_x        = 32'(cx + scaled_offset(ox, mul));
         v.pos_y        = 32'(cy + scaled_offset(oy, mul));
         v.tex_u        = 17'(ox + 32768);
         v.tex_v        = 17'(oy + 32768);
         v.last         = (k == 9);
         vertices_due.push_back(v);
      end
   endfunction

   // random gauge request, mostly well-formed levels with corner hits mixed in
   function automatic req_type random_gauge();
      req_type r;
      r.center_x    = 16'($urandom);
      r.center_y    = 16'($urandom);
      r.scale_ratio = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      r.level_max   = 16'($urandom);
      r.level       = 16'($urandom);
      case ($urandom_range(0, 9))
         0:       r.level_max = 16'd0;
         1:       r.level = r.level_max + 16'($urandom_range(1, 100));
         2, 3: begin
            r.level_max = 16'($urandom_range(1, 8191) * 8);
            r.level     = 16'(r.level_max / 8 * $urandom_range(0, 8));
         end
         default: r.level = 16'($urandom_range(0, r.level_max));
      endcase
      if ($urandom_range(0, 7) == 0) r.level = 16'($urandom);
      return r;
   endfunction

   // sender: request driver with random idle bursts
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_gauge_vertices(req_data);
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap  = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: response checker and stall generator
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (vertices_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected vertex %p", rsp_data);
            end else begin
               want = vertices_due.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("vertex mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_stall    <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap  = recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap  = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_QUARTER: cfg_quarter = val[1:0];
         CSR_REVERSE:       cfg_reverse = val[0];
         CSR_GAUGE_SIZE:    cfg_size    = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_valid || vertices_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] q, input logic [15:0] rv,
                            input logic [15:0] sz);
      wait_idle();
      csr_write(CSR_START_QUARTER, q);
      csr_write(CSR_REVERSE, rv);
      csr_write(CSR_GAUGE_SIZE, sz);
   endtask

   task automatic add_gauge(input int cx, input int cy, input int lv, input int mx, input int sr);
      req_type r;
      r.center_x    = 16'(cx);
      r.center_y    = 16'(cy);
      r.level       = 16'(lv);
      r.level_max   = 16'(mx);
      r.scale_ratio = 16'(sr);
      pending_requests.push_back(r);
   endtask

   task automatic add_random(input int n);
      for (int i = 0; i < n; i++) pending_requests.push_back(random_gauge());
   endtask

   // stimulus sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, empty gauge, overfill, full turn, corners
      add_gauge(0, 0, 0, 0, 256);
      add_gauge(-32768, 32767, 65535, 1, 65535);
      add_gauge(32767, -32768, 65535, 65535, 0);
      add_gauge(100, 200, 1, 8, 256);
      add_gauge(-5, 7, 3, 8, 512);
      add_gauge(0, 0, 5, 8, 256);
      add_gauge(0, 0, 7, 8, 300);
      add_gauge(0, 0, 1000, 3000, 256);
      add_gauge(-1, -1, 12345, 54321, 65535);
      add_gauge(1234, -4321, 65535, 65534, 1);
      configure(16'hfffd, 16'hfffe, 16'd12800);   // upper bits ignored
      csr_write(2'd3, 16'hffff);                  // unmapped index
      add_gauge(0, 0, 1, 8, 256);
      add_gauge(0, 0, 3, 8, 256);
      add_gauge(-32768, -32768, 65535, 65535, 65535);
      add_gauge(50, 60, 2, 3, 256);
      add_random(8);

      configure(16'd3, 16'd1, 16'd65535);
      add_random(5);
      add_gauge(32767, 32767, 65535, 65535, 65535);
      configure(16'd2, 16'd1, 16'd0);
      add_random(10);

      // long receiver hold while requests keep coming
      configure(16'd1, 16'd0, 16'd256);
      @(negedge clock);
      hold_pending = 1'b1;
      add_random(40);

      for (int p = 0; p < 6; p++) begin
         configure(16'($urandom), 16'($urandom), 16'($urandom));
         add_random(50);
      end

      // closing stretch with no idling
      configure(16'($urandom), 16'($urandom), 16'($urandom_range(0, 20000)));
      quiet = 1'b1;
      add_random(40);
      wait_idle();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
